// ===== design/dott_pkg.sv =====
package dott_pkg;

	localparam int NowW    = 48;
	localparam int PeriodW = 32;
	localparam int MaxOut  = 16;
	localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		KIND_ADD     = 3'd0,
		KIND_CANCEL  = 3'd1,
		KIND_REFRESH = 3'd2,
		KIND_RESET   = 3'd3,
		KIND_QUERY   = 3'd4,
		KIND_COLLECT = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOT_ARM = 2'd1,
		ST_FULL    = 2'd2,
		ST_NONE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_EMIT,
		S_DONE
	} state_t;

	// saturating add of a 32-bit period to a 48-bit time
	function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[48] ? Mask48 : s[47:0];
	endfunction

endpackage

// ===== design/dott_mem.sv =====
module dott_mem #(
	parameter int Depth = 16,
	parameter int AW = 4
) (
	input  logic        clk,
	input  logic        we,
	input  logic [AW-1:0] waddr,
	input  logic [80:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [80:0] rdata
);
	// repeat, period, deadline per slot
	logic [80:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/deadline_ordered_timer_table_core.sv =====
// Deadline-ordered timer table.
// Issue a command by raising start with kind, slot_id, period_ms, repeat_req,
// rebase_now and now_ms; it is taken when start is high and busy is low.
// busy falls in the cycle that shows the last result of the command.
// Each result appears for one cycle on result_slot, status, delay_ms,
// new_front and last, marked by valid; last flags the final one.
// Slot data lives in a synchronous memory with one read and one write port.
// Every scan reads all TIMER_SLOTS entries, one a cycle, and is followed by an
// update step. Cancel, refresh, query, add on a full table and a reset that
// takes no effect run one scan; the result shows as busy falls.
// Add with a free slot and a period reset that takes effect run a second scan
// for the front check. Collect runs one scan and update per emitted slot, at
// most 16 per request, and one scan when no slot has expired.
// Armed bits and the front flag are cleared by arst_n; other slot data is
// unknown until written. No clearing pass is needed after reset.
// The receiver cannot stall: results must be taken as they appear.
module deadline_ordered_timer_table_core #(
	parameter int TIMER_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [3:0]  slot_id,
	input  logic [31:0] period_ms,
	input  logic        repeat_req,
	input  logic        rebase_now,
	input  logic [47:0] now_ms,
	output logic        valid,
	output logic [3:0]  result_slot,
	output logic [1:0]  status,
	output logic [47:0] delay_ms,
	output logic        new_front,
	output logic        last
);
	localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1) + 1;

	dott_pkg::state_t state_q, state_d;

	// request registers
	logic [2:0]  kind_q;
	logic [3:0]  sid_q;
	logic [31:0] per_q;
	logic        rep_q, fnow_q;
	logic [47:0] now_q;

	logic [TIMER_SLOTS-1:0] armed_q;
	logic [TIMER_SLOTS-1:0] taken_q;
	logic        front_q;

	// scan
	logic [CW-1:0] cnt_q;
	logic          rd_v_s1;
	logic [AW-1:0] rd_a_s1;
	logic          found_q;
	logic          more_q;  // a second expired slot was seen in this pass
	logic [AW-1:0] best_q;
	logic [47:0]   bdl_q;
	logic [4:0]    nout_q;
	logic          free_found_q;
	logic [AW-1:0] free_q;
	logic [80:0]   tgt_q;   // entry of the addressed slot; for collect, of the chosen slot
	logic          beats_q; // some other armed slot precedes the target

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [80:0]   wdata, rdata;

	dott_mem #(.Depth(TIMER_SLOTS), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [31:0]   r_per;
	logic [47:0]   r_dl;
	assign r_per = rdata[79:48];
	assign r_dl  = rdata[47:0];

	logic sid_ok;
	logic [AW-1:0] sid_a;
	assign sid_ok = ({28'd0, sid_q} < 32'(TIMER_SLOTS));
	assign sid_a  = AW'(sid_q);

	// target entry after the command's write, for front check
	logic [47:0] t_dl_new;
	logic [47:0] start_t;
	always_comb begin
		if (fnow_q) begin
			start_t = now_q;
		end else if (tgt_q[47:0] >= {16'd0, tgt_q[79:48]}) begin
			start_t = tgt_q[47:0] - {16'd0, tgt_q[79:48]};
		end else begin
			start_t = '0;
		end
		if (kind_q == dott_pkg::KIND_ADD) begin
			t_dl_new = dott_pkg::sat_add(now_q, per_q);
		end else begin
			t_dl_new = dott_pkg::sat_add(start_t, per_q);
		end
	end

	logic [AW-1:0] tgt_a;
	assign tgt_a = (kind_q == dott_pkg::KIND_ADD) ? free_q : sid_a;

	// candidate from the current read
	logic cand;
	logic elig;
	logic idx_before_tgt;
	logic read_precedes;
	always_comb begin
		cand = 1'b0;
		elig = 1'b0;
		idx_before_tgt = rd_a_s1 < tgt_a;
		read_precedes = (r_dl < t_dl_new) || (r_dl == t_dl_new && idx_before_tgt);
		if (rd_v_s1 && armed_q[rd_a_s1]) begin
			case (kind_q)
				dott_pkg::KIND_QUERY: begin
					cand = !found_q || r_dl < bdl_q;
				end
				dott_pkg::KIND_COLLECT: begin
					elig = !taken_q[rd_a_s1] && r_dl <= now_q;
					cand = elig && (!found_q || r_dl < bdl_q);
				end
				default: cand = 1'b0;
			endcase
		end
	end

	logic scan_end;
	assign scan_end = (cnt_q == CW'(TIMER_SLOTS)) && !rd_v_s1;

	always_comb begin
		state_d = state_q;
		busy = (state_q != dott_pkg::S_IDLE);
		raddr = AW'(cnt_q);
		case (state_q)
			dott_pkg::S_IDLE: if (start) state_d = dott_pkg::S_SCAN;
			dott_pkg::S_SCAN: if (scan_end) state_d = dott_pkg::S_ACT;
			dott_pkg::S_ACT: begin
				if (kind_q == dott_pkg::KIND_ADD && free_found_q) begin
					state_d = dott_pkg::S_EMIT;
				end else if (kind_q == dott_pkg::KIND_RESET && sid_ok && armed_q[sid_a]
					&& !(!fnow_q && per_q == tgt_q[79:48])) begin
					state_d = dott_pkg::S_EMIT;
				end else if (kind_q == dott_pkg::KIND_COLLECT && found_q && more_q
					&& nout_q != 5'(dott_pkg::MaxOut - 1)) begin
					state_d = dott_pkg::S_SCAN;
				end else begin
					state_d = dott_pkg::S_IDLE;
				end
			end
			// second pass for the front check
			dott_pkg::S_EMIT: if (scan_end) state_d = dott_pkg::S_DONE;
			dott_pkg::S_DONE: state_d = dott_pkg::S_IDLE;
			default: state_d = dott_pkg::S_IDLE;
		endcase
		// addressed slot is read first on the first pass
		if (state_q == dott_pkg::S_IDLE) raddr = AW'(slot_id);
	end

	// write port: driven in S_ACT
	always_comb begin
		we = 1'b0;
		waddr = sid_a;
		wdata = tgt_q;
		if (state_q == dott_pkg::S_ACT) begin
			case (kind_q)
				dott_pkg::KIND_ADD: begin
					we = free_found_q;
					waddr = free_q;
					wdata = {rep_q, per_q, t_dl_new};
				end
				dott_pkg::KIND_REFRESH: begin
					we = sid_ok && armed_q[sid_a];
					wdata = {tgt_q[80:48], dott_pkg::sat_add(now_q, tgt_q[79:48])};
				end
				dott_pkg::KIND_RESET: begin
					we = sid_ok && armed_q[sid_a] && !(!fnow_q && per_q == tgt_q[79:48]);
					wdata = {tgt_q[80], per_q, t_dl_new};
				end
				dott_pkg::KIND_COLLECT: begin
					we = found_q && tgt_q[80];
					waddr = best_q;
					wdata = {tgt_q[80:48], dott_pkg::sat_add(now_q, tgt_q[79:48])};
				end
				default: we = 1'b0;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dott_pkg::S_IDLE;
			armed_q <= '0;
			front_q <= 1'b0;
			valid <= 1'b0;
			rd_v_s1 <= 1'b0;
			cnt_q <= '0;
			found_q <= 1'b0;
			more_q <= 1'b0;
			free_found_q <= 1'b0;
			beats_q <= 1'b0;
			nout_q <= '0;
			taken_q <= '0;
		end else begin
			state_q <= state_d;
			valid <= 1'b0;
			rd_v_s1 <= 1'b0;
			case (state_q)
				dott_pkg::S_IDLE: begin
					cnt_q <= '0;
					found_q <= 1'b0;
					more_q <= 1'b0;
					free_found_q <= 1'b0;
					beats_q <= 1'b0;
					nout_q <= '0;
					taken_q <= '0;
					rd_v_s1 <= 1'b0;
				end
				dott_pkg::S_SCAN, dott_pkg::S_EMIT: begin
					if (cnt_q != CW'(TIMER_SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end
					if (rd_v_s1) begin
						if (!armed_q[rd_a_s1] && !free_found_q) free_found_q <= 1'b1;
						if (cand) found_q <= 1'b1;
						if (elig && found_q) more_q <= 1'b1;
						if (state_q == dott_pkg::S_EMIT && armed_q[rd_a_s1]
							&& rd_a_s1 != tgt_a && read_precedes) beats_q <= 1'b1;
					end
				end
				dott_pkg::S_ACT: begin
					cnt_q <= '0;
					found_q <= 1'b0;
					more_q <= 1'b0;
					valid <= 1'b1;
					case (kind_q)
						dott_pkg::KIND_ADD: if (free_found_q) begin
							armed_q[free_q] <= 1'b1;
							valid <= 1'b0;
						end
						dott_pkg::KIND_CANCEL: if (sid_ok) armed_q[sid_a] <= 1'b0;
						dott_pkg::KIND_RESET: if (state_d == dott_pkg::S_EMIT) valid <= 1'b0;
						dott_pkg::KIND_QUERY: front_q <= 1'b0;
						dott_pkg::KIND_COLLECT: if (found_q) begin
							taken_q[best_q] <= 1'b1;
							nout_q <= nout_q + 1'b1;
							if (!tgt_q[80]) armed_q[best_q] <= 1'b0;
						end else if (nout_q != '0) begin
							valid <= 1'b0;
						end
						default: ;
					endcase
				end
				dott_pkg::S_DONE: begin
					valid <= 1'b1;
					if (!beats_q && !front_q) front_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_a_s1 <= AW'(cnt_q);
		if (state_q == dott_pkg::S_IDLE && start) begin
			kind_q <= kind; sid_q <= slot_id; per_q <= period_ms;
			rep_q <= repeat_req; fnow_q <= rebase_now; now_q <= now_ms;
		end
		if (state_q == dott_pkg::S_SCAN && rd_v_s1) begin
			if (!armed_q[rd_a_s1] && !free_found_q) free_q <= rd_a_s1;
			if (cand) begin
				best_q <= rd_a_s1;
				bdl_q <= r_dl;
				if (kind_q == dott_pkg::KIND_COLLECT) tgt_q <= rdata;
			end
			if (rd_a_s1 == sid_a && kind_q != dott_pkg::KIND_COLLECT) tgt_q <= rdata;
		end
		// result fields
		if (state_q == dott_pkg::S_ACT) begin
			result_slot <= 4'(sid_q);
			status <= dott_pkg::ST_OK;
			delay_ms <= '0;
			new_front <= 1'b0;
			last <= 1'b1;
			case (kind_q)
				dott_pkg::KIND_ADD: begin
					result_slot <= 4'(free_q);
					if (!free_found_q) begin
						result_slot <= '0;
						status <= dott_pkg::ST_FULL;
					end
				end
				dott_pkg::KIND_CANCEL, dott_pkg::KIND_REFRESH, dott_pkg::KIND_RESET: begin
					if (!sid_ok) status <= dott_pkg::ST_NOT_ARM;
					else if (kind_q == dott_pkg::KIND_RESET && !fnow_q
						&& per_q == tgt_q[79:48]) status <= dott_pkg::ST_OK;
					else if (!armed_q[sid_a]) status <= dott_pkg::ST_NOT_ARM;
				end
				dott_pkg::KIND_QUERY: begin
					result_slot <= '0;
					if (!found_q) delay_ms <= dott_pkg::Mask48;
					else if (now_q >= bdl_q) delay_ms <= '0;
					else delay_ms <= bdl_q - now_q;
				end
				dott_pkg::KIND_COLLECT: begin
					result_slot <= 4'(best_q);
					// final result when no other expired slot is left or the limit is hit
					last <= (nout_q == 5'(dott_pkg::MaxOut - 1)) || !more_q;
					if (!found_q) begin
						result_slot <= '0;
						status <= dott_pkg::ST_NONE;
					end
				end
				default: begin
					result_slot <= '0;
					status <= dott_pkg::ST_NOT_ARM;
				end
			endcase
		end
		if (state_q == dott_pkg::S_DONE) begin
			new_front <= !beats_q && !front_q;
		end
	end

endmodule
